[src/pstat_pkg.sv]
package pstat_pkg;

  localparam int DEF_MAX_STATES = 16;

  localparam int STATE_W   = 4;
  localparam int ACTIVE_W  = 5;
  localparam int BLOCKED_W = 4;
  localparam int TIME_W    = 64;
  localparam int COUNT_W   = 64;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_STATES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKED_TOP   = 1'b1;

  localparam logic [ACTIVE_W-1:0]  DEF_ACTIVE_STATES = 5'd16;
  localparam logic [BLOCKED_W-1:0] DEF_BLOCKED_TOP   = 4'd0;

  localparam logic [1:0] OP_TRANSITION = 2'd0;
  localparam logic [1:0] OP_SETTLE     = 2'd1;
  localparam logic [1:0] OP_READ       = 2'd2;
  localparam logic [1:0] OP_RESET      = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  idle_time;
    logic [STATE_W-1:0] read_row;
    logic [STATE_W-1:0] read_col;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [STATE_W-1:0]  last_state;
    logic [STATE_W-1:0]  cur_state;
    logic [TIME_W-1:0]   residency_ns;
    logic [COUNT_W-1:0]  enter_count;
    logic [COUNT_W-1:0]  transition_count;
    logic [ACTIVE_W-1:0] total_states;
    logic [ACTIVE_W-1:0] usable_states;
  } rsp_t;

endpackage

[src/pstat_if.sv]
interface pstat_req_if;
  logic             valid;
  logic             ready;
  pstat_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pstat_rsp_if;
  logic             valid;
  logic             ready;
  pstat_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/pstate_residency_transition_stats_top.sv]
// A request is registered with its memory rows read at its transfer; in ST_EXEC the result is registered
// onto rsp once the rsp slot is free, so a stalled rsp holds the block in ST_EXEC. Requests are taken
// only in ST_IDLE: no new request is taken until the last one has been executed.
// A reset-statistics request is followed by a clearing pass over every address of the memories,
// during which no request is taken.
// Reset (rst, synchronous) runs the same clearing pass and loads the register defaults.
module pstate_residency_transition_stats_top #(
  parameter int MAX_STATES = pstat_pkg::DEF_MAX_STATES
) (
  input  logic                               clk,
  input  logic                               rst,
  pstat_req_if.sink                          req,
  pstat_rsp_if.source                        rsp,
  input  logic                               cfg_we,
  input  logic [pstat_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pstat_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW     = $clog2(MAX_STATES);
  localparam int RDEPTH = 1 << SW;
  localparam int MW     = 2 * SW;
  localparam int MDEPTH = 1 << MW;
  localparam int NB     = $clog2(MAX_STATES + 1);
  localparam int BW     = (pstat_pkg::ACTIVE_W > NB) ? pstat_pkg::ACTIVE_W : NB;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t state;
  logic [MW-1:0] clr_addr;

  logic [pstat_pkg::ACTIVE_W-1:0]  active_states;
  logic [pstat_pkg::BLOCKED_W-1:0] blocked_top;
  logic [pstat_pkg::TIME_W-1:0]    prev_wall;
  logic [pstat_pkg::TIME_W-1:0]    prev_idle;
  logic [pstat_pkg::STATE_W-1:0]   last_rec;
  logic [pstat_pkg::STATE_W-1:0]   cur_rec;

  pstat_pkg::req_t              item;
  logic [pstat_pkg::TIME_W-1:0] busy_ns;
  logic [SW-1:0]                res_a;
  logic [SW-1:0]                ent_a;
  logic [MW-1:0]                mtx_a;

  logic [pstat_pkg::TIME_W-1:0]  res_mem [RDEPTH];
  logic [pstat_pkg::COUNT_W-1:0] ent_mem [RDEPTH];
  logic [pstat_pkg::COUNT_W-1:0] mtx_mem [MDEPTH];
  logic [pstat_pkg::TIME_W-1:0]  res_rd;
  logic [pstat_pkg::COUNT_W-1:0] ent_rd;
  logic [pstat_pkg::COUNT_W-1:0] mtx_rd;

  logic            rsp_valid;
  pstat_pkg::rsp_t rsp_data;

  logic                          acc;
  logic [SW-1:0]                 res_raddr;
  logic [SW-1:0]                 ent_raddr;
  logic [MW-1:0]                 mtx_raddr;
  logic [pstat_pkg::TIME_W-1:0]  busy_calc;
  logic [BW-1:0]                 bound;
  logic                          from_ok, to_ok, cur_ok, row_ok, col_ok;
  logic                          trans_ok, settle_ok, read_ok;
  logic                          slot_free, fire, clearing;
  logic                          res_we, ent_we, mtx_we;
  logic [SW-1:0]                 res_waddr, ent_waddr;
  logic [MW-1:0]                 mtx_waddr;
  logic [pstat_pkg::TIME_W-1:0]  res_wdata;
  logic [pstat_pkg::COUNT_W-1:0] ent_wdata, mtx_wdata;
  pstat_pkg::rsp_t               rsp_next;

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;

  // Read addresses come from the request (the settle residency address from cur_rec) so the data is there in ST_EXEC.
  always_comb begin
    case (req.payload.op)
      pstat_pkg::OP_TRANSITION: begin
        res_raddr = SW'(req.payload.from_state);
        ent_raddr = SW'(req.payload.to_state);
        mtx_raddr = {SW'(req.payload.from_state), SW'(req.payload.to_state)};
      end
      pstat_pkg::OP_SETTLE: begin
        res_raddr = SW'(cur_rec);
        ent_raddr = SW'(req.payload.read_row);
        mtx_raddr = {SW'(req.payload.read_row), SW'(req.payload.read_col)};
      end
      default: begin
        res_raddr = SW'(req.payload.read_row);
        ent_raddr = SW'(req.payload.read_row);
        mtx_raddr = {SW'(req.payload.read_row), SW'(req.payload.read_col)};
      end
    endcase
  end

  assign busy_calc = (req.payload.now_time - prev_wall) - (req.payload.idle_time - prev_idle);

  assign bound = (BW'(active_states) < BW'(MAX_STATES)) ? BW'(active_states) : BW'(MAX_STATES);

  assign from_ok = BW'(item.from_state) < bound;
  assign to_ok   = BW'(item.to_state) < bound;
  assign cur_ok  = BW'(cur_rec) < bound;
  assign row_ok  = BW'(item.read_row) < bound;
  assign col_ok  = BW'(item.read_col) < bound;

  assign trans_ok  = (item.op == pstat_pkg::OP_TRANSITION) && from_ok && to_ok;
  assign settle_ok = (item.op == pstat_pkg::OP_SETTLE) && cur_ok;
  assign read_ok   = (item.op == pstat_pkg::OP_READ) && row_ok && col_ok;

  assign slot_free = !rsp_valid || rsp.ready;
  assign fire      = (state == ST_EXEC) && slot_free;
  assign clearing  = (state == ST_CLEAR);

  // Busy time is dropped when the difference is negative.
  assign res_we = clearing || (fire && (trans_ok || settle_ok) && !busy_ns[pstat_pkg::TIME_W-1]);
  assign ent_we = clearing || (fire && trans_ok);
  assign mtx_we = clearing || (fire && trans_ok);

  assign res_waddr = clearing ? clr_addr[SW-1:0] : res_a;
  assign ent_waddr = clearing ? clr_addr[SW-1:0] : ent_a;
  assign mtx_waddr = clearing ? clr_addr : mtx_a;

  assign res_wdata = clearing ? '0 : res_rd + busy_ns;
  assign ent_wdata = clearing ? '0 : ent_rd + pstat_pkg::COUNT_W'(1);
  assign mtx_wdata = clearing ? '0 : mtx_rd + pstat_pkg::COUNT_W'(1);

  always_comb begin
    rsp_next = '0;
    rsp_next.status = (item.op != pstat_pkg::OP_RESET && !(trans_ok || settle_ok || read_ok))
                      ? pstat_pkg::STATUS_RANGE : pstat_pkg::STATUS_OK;
    rsp_next.last_state   = trans_ok ? item.from_state : last_rec;
    rsp_next.cur_state    = trans_ok ? item.to_state : cur_rec;
    rsp_next.total_states = active_states;
    rsp_next.usable_states = (active_states > pstat_pkg::ACTIVE_W'(blocked_top))
        ? active_states - pstat_pkg::ACTIVE_W'(blocked_top) : '0;
    if (read_ok) begin
      rsp_next.residency_ns     = res_rd;
      rsp_next.enter_count      = ent_rd;
      rsp_next.transition_count = mtx_rd;
    end
  end

  // State memories
  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (acc) res_rd <= res_mem[res_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (acc) ent_rd <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (mtx_we) mtx_mem[mtx_waddr] <= mtx_wdata;
    if (acc) mtx_rd <= mtx_mem[mtx_raddr];
  end

  // Request hold
  always_ff @(posedge clk) begin
    if (acc) begin
      item    <= req.payload;
      busy_ns <= busy_calc;
      res_a   <= res_raddr;
      ent_a   <= ent_raddr;
      mtx_a   <= mtx_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) rsp_data <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      rsp_valid     <= 1'b0;
      prev_wall     <= '0;
      prev_idle     <= '0;
      last_rec      <= '0;
      cur_rec       <= '0;
      active_states <= pstat_pkg::DEF_ACTIVE_STATES;
      blocked_top   <= pstat_pkg::DEF_BLOCKED_TOP;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pstat_pkg::CFG_ACTIVE_STATES:
            active_states <= cfg_data[pstat_pkg::ACTIVE_W-1:0];
          pstat_pkg::CFG_BLOCKED_TOP:
            blocked_top <= cfg_data[pstat_pkg::BLOCKED_W-1:0];
          default: ;
        endcase
      end

      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (fire && trans_ok) begin
        last_rec <= item.from_state;
        cur_rec  <= item.to_state;
      end

      // Advance the stamps on every update that was taken and on a reset request, negative busy time included.
      if (fire && (trans_ok || settle_ok || item.op == pstat_pkg::OP_RESET)) begin
        prev_wall <= item.now_time;
        prev_idle <= item.idle_time;
      end

      case (state)
        ST_IDLE: begin
          if (acc) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (fire) state <= (item.op == pstat_pkg::OP_RESET) ? ST_CLEAR : ST_IDLE;
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + MW'(1);
          if (&clr_addr) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !rsp.valid) |=> ##1 rsp.valid)
    else $error("result not offered two cycles after request transfer");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    (res_we || ent_we || mtx_we) |-> !(req.valid && req.ready))
    else $error("memory write coincides with request transfer");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (BW'(cur_rec) < BW'(MAX_STATES)) && (BW'(last_rec) < BW'(MAX_STATES)))
    else $error("recorded state beyond memory depth");
`endif

endmodule
